// ===== src/wph_pkg.sv =====
// ----------------------------------------------------------------------------
// wph_pkg
// Shared types and constants of the WAV 8-bit PCM header parser.
// ----------------------------------------------------------------------------
package wph_pkg;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_BAD    = 2'd2;
  localparam logic [1:0] KIND_IGNORE = 2'd3;

  // "RIFF", four length bytes, "WAVE", "fmt " with byte 0 in the low bits
  localparam logic [127:0] MAGIC_TEXT = 128'h2074_6d66_4556_4157_0000_0000_4646_4952;
  // "data" with byte 0 in the low bits
  localparam logic [31:0]  DATA_TEXT  = 32'h6174_6164;

  // classified input byte travelling from front to back
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        new_file;
    logic [15:0] magic_hit;
    logic [3:0]  data_hit;
  } item_t;

endpackage

// ===== src/wph_front.sv =====
// ----------------------------------------------------------------------------
// wph_front
// Accepts file bytes and matches each against the magic and chunk id text.
// ----------------------------------------------------------------------------
module wph_front (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,  // data_byte
  input  logic [0:0]        s_axis_tuser,  // new_file
  input  logic              queue_ready,
  output logic              push,
  output wph_pkg::item_t    push_item
);
  import wph_pkg::*;

  always_comb begin
    push_item.data_byte = s_axis_tdata;
    push_item.new_file  = s_axis_tuser[0];
    for (int i = 0; i < 16; i++) begin
      push_item.magic_hit[i] = (s_axis_tdata == MAGIC_TEXT[8*i +: 8]);
    end
    for (int i = 0; i < 4; i++) begin
      push_item.data_hit[i] = (s_axis_tdata == DATA_TEXT[8*i +: 8]);
    end
  end

  assign s_axis_tready = queue_ready;
  assign push          = s_axis_tvalid && queue_ready;

endmodule

// ===== src/wph_queue.sv =====
// ----------------------------------------------------------------------------
// wph_queue
// Short queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module wph_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wph_pkg::item_t push_item,
  output logic           in_ready,
  input  logic           pop,
  output wph_pkg::item_t pop_item,
  output logic           out_valid
);
  import wph_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/wph_back.sv =====
// ----------------------------------------------------------------------------
// wph_back
// Header parser state machine and registered result stage.
// ----------------------------------------------------------------------------
module wph_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  wph_pkg::item_t item,
  output logic           pop,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [71:0]    m_axis_tdata,  // sample, sample_rate, data_length
  output logic [1:0]     m_axis_tuser,  // kind
  output logic           m_axis_tlast   // last_sample
);
  import wph_pkg::*;

  localparam logic [2:0] PH_HEADER    = 3'd0;
  localparam logic [2:0] PH_SKIP      = 3'd1;
  localparam logic [2:0] PH_CHUNK_ID  = 3'd2;
  localparam logic [2:0] PH_CHUNK_LEN = 3'd3;
  localparam logic [2:0] PH_DATA_LEN  = 3'd4;
  localparam logic [2:0] PH_SAMPLES   = 3'd5;
  localparam logic [2:0] PH_ERROR     = 3'd6;
  localparam logic [2:0] PH_DONE      = 3'd7;

  function automatic logic [31:0] take_byte(input logic [31:0] acc, input logic [7:0] b,
                                            input logic [1:0] off);
    logic [31:0] r;
    case (off)
      2'd0:    r = {24'd0, b};
      2'd1:    r = acc | {16'd0, b, 8'd0};
      2'd2:    r = acc | {8'd0, b, 16'd0};
      default: r = acc | {b, 24'd0};
    endcase
    return r;
  endfunction

  logic [2:0]  phase, phase_next;
  logic [1:0]  bpos, bpos_next;
  logic [31:0] acc, acc_next;
  logic        inv, inv_next;
  logic [31:0] rate, rate_next;
  logic [31:0] len, len_next;
  logic [31:0] cnt, cnt_next;

  logic [2:0]  c_phase;
  logic [1:0]  c_bpos;
  logic [31:0] c_acc;
  logic        c_inv;
  logic [31:0] c_rate;
  logic [31:0] c_len;
  logic [31:0] c_cnt;
  logic [31:0] cnt_dec;
  logic [31:0] acc_v;
  logic        inv_v;
  logic [5:0]  p;
  logic [1:0]  off;
  logic [1:0]  kind_c;
  logic [7:0]  smp_c;
  logic        last_c;
  logic [31:0] dlen_c;

  assign pop = item_valid && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    c_phase = item.new_file ? PH_HEADER : phase;
    c_bpos  = item.new_file ? 2'd0  : bpos;
    c_acc   = item.new_file ? 32'd0 : acc;
    c_inv   = item.new_file ? 1'b0  : inv;
    c_rate  = item.new_file ? 32'd0 : rate;
    c_len   = item.new_file ? 32'd0 : len;
    c_cnt   = item.new_file ? 32'd0 : cnt;

    phase_next = c_phase;
    bpos_next  = c_bpos;
    acc_next   = c_acc;
    inv_next   = c_inv;
    rate_next  = c_rate;
    len_next   = c_len;
    cnt_next   = c_cnt;

    cnt_dec = c_cnt - 32'd1;
    p       = c_cnt[5:0];
    off     = ((p < 6'd20) || ((p >= 6'd24) && (p < 6'd32))) ? p[1:0] : {1'b0, p[0]};
    acc_v   = '0;
    inv_v   = c_inv;
    kind_c  = KIND_HEADER;
    smp_c   = 8'd0;
    last_c  = 1'b0;

    case (c_phase)
      PH_HEADER: begin
        if (p < 6'd16) begin
          inv_v    = c_inv | (((p < 6'd4) || (p >= 6'd8)) && !item.magic_hit[p[3:0]]);
          inv_next = inv_v;
          if ((p == 6'd15) && inv_v) begin
            phase_next = PH_ERROR;
            kind_c     = KIND_BAD;
          end else begin
            cnt_next = c_cnt + 32'd1;
          end
        end else begin
          acc_v    = take_byte(c_acc, item.data_byte, off);
          acc_next = acc_v;
          cnt_next = c_cnt + 32'd1;
          case (p)
            6'd19: len_next = acc_v;
            6'd21, 6'd23, 6'd33: begin
              if (acc_v != 32'd1) inv_next = 1'b1;
            end
            6'd27: rate_next = acc_v;
            6'd31: begin
              if (acc_v != c_rate) inv_next = 1'b1;
            end
            6'd35: begin
              inv_v    = c_inv | (acc_v != 32'd8);
              inv_next = inv_v;
              if (inv_v) begin
                phase_next = PH_ERROR;
                kind_c     = KIND_BAD;
                cnt_next   = c_cnt;
              end else begin
                if (!c_len[31] && (c_len > 32'd16)) begin
                  cnt_next   = c_len - 32'd16;
                  phase_next = PH_SKIP;
                end else begin
                  cnt_next   = 32'd0;
                  phase_next = PH_CHUNK_ID;
                end
                len_next  = 32'd0;
                bpos_next = 2'd0;
              end
            end
            default: ;
          endcase
        end
      end
      PH_SKIP: begin
        cnt_next = cnt_dec;
        if (cnt_dec == 32'd0) begin
          phase_next = PH_CHUNK_ID;
          bpos_next  = 2'd0;
        end
      end
      PH_CHUNK_ID: begin
        inv_v = c_inv | !item.data_hit[c_bpos];
        if (c_bpos == 2'd3) begin
          phase_next = inv_v ? PH_CHUNK_LEN : PH_DATA_LEN;
          inv_next   = 1'b0;
          bpos_next  = 2'd0;
        end else begin
          inv_next  = inv_v;
          bpos_next = c_bpos + 2'd1;
        end
      end
      PH_CHUNK_LEN: begin
        acc_v    = take_byte(c_acc, item.data_byte, c_bpos);
        acc_next = acc_v;
        if (c_bpos == 2'd3) begin
          bpos_next  = 2'd0;
          cnt_next   = acc_v;
          phase_next = (acc_v == 32'd0) ? PH_CHUNK_ID : PH_SKIP;
        end else begin
          bpos_next = c_bpos + 2'd1;
        end
      end
      PH_DATA_LEN: begin
        acc_v    = take_byte(c_acc, item.data_byte, c_bpos);
        acc_next = acc_v;
        if (c_bpos == 2'd3) begin
          bpos_next  = 2'd0;
          len_next   = acc_v;
          cnt_next   = acc_v;
          phase_next = (acc_v == 32'd0) ? PH_DONE : PH_SAMPLES;
        end else begin
          bpos_next = c_bpos + 2'd1;
        end
      end
      PH_SAMPLES: begin
        kind_c   = KIND_SAMPLE;
        smp_c    = item.data_byte;
        cnt_next = cnt_dec;
        if (cnt_dec == 32'd0) begin
          last_c     = 1'b1;
          phase_next = PH_DONE;
        end
      end
      PH_ERROR: kind_c = KIND_BAD;
      default:  kind_c = KIND_IGNORE;
    endcase

    dlen_c = ((phase_next == PH_SAMPLES) || (phase_next == PH_DONE)) ? len_next : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      bpos  <= 2'd0;
      acc   <= 32'd0;
      inv   <= 1'b0;
      rate  <= 32'd0;
      len   <= 32'd0;
      cnt   <= 32'd0;
    end else if (pop) begin
      phase <= phase_next;
      bpos  <= bpos_next;
      acc   <= acc_next;
      inv   <= inv_next;
      rate  <= rate_next;
      len   <= len_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_axis_tdata <= {dlen_c, rate_next, smp_c};
      m_axis_tuser <= kind_c;
      m_axis_tlast <= last_c;
    end
  end

  // a marked last transfer is always a sample
  a_last_is_sample: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == KIND_SAMPLE))
    else $error("last marked on a non-sample result");

  // while streaming samples some bytes are always left
  a_samples_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SAMPLES) |-> (cnt != 32'd0))
    else $error("sample phase with no bytes left");

  // fixed header offset stays inside the 36-byte header
  a_header_offset: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HEADER) |-> (cnt < 32'd36))
    else $error("header offset out of range");

  // error phase is sticky until a new file starts
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (pop && (phase == PH_ERROR) && !item.new_file) |=> (phase == PH_ERROR))
    else $error("left error phase without new file");

endmodule

// ===== src/wav_pcm8_header_parser.sv =====
// each byte is written into the queue, then popped by the back stage, which registers its result on the output
// throughput: one byte per cycle while the output is not stalled; the back stage parses each byte as it pops it
// a 2-entry queue lets the front take one more byte while the output is stalled
// reset: synchronous rst returns to the RIFF magic check, no clearing pass
// new_file on a byte restarts parsing from that byte
// ----------------------------------------------------------------------------
// wav_pcm8_header_parser
// Byte-serial WAV parser for mono 8-bit PCM: checks the header, skips chunks
// and streams the data chunk as samples.
// ----------------------------------------------------------------------------
module wav_pcm8_header_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic [0:0]  s_axis_tuser,  // new_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // sample[7:0], sample_rate[39:8], data_length[71:40]
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast   // last_sample
);
  import wph_pkg::*;

  logic  push;
  logic  queue_ready;
  item_t push_item;
  logic  pop;
  logic  queue_valid;
  item_t pop_item;

  wph_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .queue_ready   (queue_ready),
    .push          (push),
    .push_item     (push_item)
  );

  wph_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .in_ready  (queue_ready),
    .pop       (pop),
    .pop_item  (pop_item),
    .out_valid (queue_valid)
  );

  wph_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (queue_valid),
    .item          (pop_item),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== verif/tb_wav_pcm8_header_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wav_pcm8_header_parser
// Streams WAV byte images through the parser: good mono 8-bit PCM files with
// random rates, fmt extensions, skipped chunks and data, plus bad magics, bad
// fmt fields, restarts and noise. A byte-level parse model predicts one result
// per accepted byte; the monitor checks each output transfer in order.
// ----------------------------------------------------------------------------
module tb_wav_pcm8_header_parser;
  import wph_pkg::*;

  typedef enum logic [2:0] {
    P_HDR, P_SKIP, P_CID, P_CLEN, P_DLEN, P_SMP, P_ERR, P_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] b;
    logic       nf;
  } in_byte_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  smp;
    logic        lst;
    logic [31:0] rate;
    logic [31:0] dlen;
  } wav_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;  // data_byte
  logic [0:0]  s_axis_tuser = 1'b0;  // new_file
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;         // sample, sample_rate, data_length
  logic [1:0]  m_axis_tuser;         // kind
  logic        m_axis_tlast;

  wav_pcm8_header_parser uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // parse model state
  parse_phase_t ph = P_HDR;
  logic [1:0]   pos = '0;
  logic [31:0]  acc = '0;
  logic         fmt_bad = 1'b0;
  logic [31:0]  rate_q = '0;
  logic [31:0]  len_q = '0;
  logic [31:0]  cnt = '0;

  in_byte_t    byte_q[$];
  wav_result_t parse_out_q[$];
  logic [7:0]  img[$];

  int src_gap = 0;
  int sink_gap = 0;
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  bit quiet = 1'b0;
  int mismatch_count = 0;
  int stim_count = 0;

  task automatic gather(input logic [7:0] b, input logic [1:0] off);
    if (off == 2'd0) acc = {24'd0, b};
    else acc = acc | ({24'd0, b} << (8 * off));
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic nf);
    wav_result_t r;
    logic [31:0] p;
    logic [1:0]  off;
    bit          hdr_end;
    r = '0;
    r.kind = KIND_HEADER;
    hdr_end = 1'b0;
    if (nf) begin
      ph = P_HDR; pos = '0; acc = '0; fmt_bad = 1'b0;
      rate_q = '0; len_q = '0; cnt = '0;
    end
    case (ph)
      P_HDR: begin
        p = cnt;
        if (p < 16) begin
          if ((p < 4 || p >= 8) && b != MAGIC_TEXT[8 * p[3:0] +: 8]) fmt_bad = 1'b1;
          if (p == 15 && fmt_bad) begin
            ph = P_ERR;
            r.kind = KIND_BAD;
          end else begin
            cnt = p + 1;
          end
        end else begin
          off = (p < 20 || (p >= 24 && p < 32)) ? p[1:0] : {1'b0, p[0]};
          gather(b, off);
          case (p)
            19: len_q = acc;
            21, 23, 33: if (acc != 32'd1) fmt_bad = 1'b1;
            27: rate_q = acc;
            31: if (acc != rate_q) fmt_bad = 1'b1;
            35: begin
              hdr_end = 1'b1;
              if (acc != 32'd8) fmt_bad = 1'b1;
              if (fmt_bad) begin
                ph = P_ERR;
                r.kind = KIND_BAD;
              end else begin
                // fmt length taken as signed
                if (!len_q[31] && len_q > 32'd16) begin
                  cnt = len_q - 32'd16;
                  ph = P_SKIP;
                end else begin
                  cnt = '0;
                  ph = P_CID;
                end
                len_q = '0;
                pos = '0;
              end
            end
            default: ;
          endcase
          if (!hdr_end) cnt = p + 1;
        end
      end
      P_SKIP: begin
        cnt = cnt - 1;
        if (cnt == 0) begin
          ph = P_CID;
          pos = '0;
        end
      end
      P_CID: begin
        if (b != DATA_TEXT[8 * pos +: 8]) fmt_bad = 1'b1;
        if (pos == 2'd3) begin
          ph = fmt_bad ? P_CLEN : P_DLEN;
          fmt_bad = 1'b0;
          pos = '0;
        end else begin
          pos = pos + 2'd1;
        end
      end
      P_CLEN: begin
        gather(b, pos);
        if (pos == 2'd3) begin
          pos = '0;
          cnt = acc;
          ph = (acc == 0) ? P_CID : P_SKIP;
        end else begin
          pos = pos + 2'd1;
        end
      end
      P_DLEN: begin
        gather(b, pos);
        if (pos == 2'd3) begin
          pos = '0;
          len_q = acc;
          cnt = acc;
          ph = (acc == 0) ? P_DONE : P_SMP;
        end else begin
          pos = pos + 2'd1;
        end
      end
      P_SMP: begin
        r.kind = KIND_SAMPLE;
        r.smp = b;
        cnt = cnt - 1;
        if (cnt == 0) begin
          r.lst = 1'b1;
          ph = P_DONE;
        end
      end
      P_ERR: r.kind = KIND_BAD;
      default: r.kind = KIND_IGNORE;
    endcase
    r.rate = rate_q;
    r.dlen = (ph == P_SMP || ph == P_DONE) ? len_q : 32'd0;
    parse_out_q.push_back(r);
  endtask

  // source side
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tuser[0]);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() != 0 && src_idle_en && !quiet &&
                     $urandom_range(0, 7) == 0) begin
          src_gap <= $urandom_range(0, 4);
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          s_axis_tdata <= byte_q[0].b;
          s_axis_tuser <= byte_q[0].nf;
          void'(byte_q.pop_front());
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    wav_result_t got;
    wav_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[39:8],
               m_axis_tdata[71:40]};
        if (parse_out_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transfer: kind %0d sample %h last %b rate %h len %h",
                     got.kind, got.smp, got.lst, got.rate, got.dlen);
        end else begin
          want = parse_out_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch (exp/act): kind %0d/%0d sample %h/%h last %b/%b rate %h/%h len %h/%h",
                       want.kind, got.kind, want.smp, got.smp, want.lst, got.lst,
                       want.rate, got.rate, want.dlen, got.dlen);
          end
        end
      end
      if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (sink_idle_en && !quiet && $urandom_range(0, 9) == 0) begin
        sink_gap <= $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) img.push_back(v[8 * i +: 8]);
  endtask

  function automatic logic [31:0] other_chunk_id();
    logic [31:0] id;
    if ($urandom_range(0, 1) == 0) begin
      // near miss of the data id
      id = DATA_TEXT;
      id[8 * $urandom_range(0, 3) +: 8] ^= 8'($urandom_range(1, 255));
    end else begin
      id = $urandom;
      if (id == DATA_TEXT) id[7:0] ^= 8'h01;
    end
    return id;
  endfunction

  task automatic make_wav(input logic [31:0] fmt_len, input logic [15:0] tag, chans,
                          input logic [31:0] rate, brate, input logic [15:0] align, bits,
                          input int n_other, other_max, input logic [31:0] data_len,
                          input int n_smp);
    int clen;
    img.delete();
    put_le(MAGIC_TEXT[31:0], 4);
    put_le($urandom, 4);
    put_le(MAGIC_TEXT[95:64], 4);
    put_le(MAGIC_TEXT[127:96], 4);
    put_le(fmt_len, 4);
    put_le({16'd0, tag}, 2);
    put_le({16'd0, chans}, 2);
    put_le(rate, 4);
    put_le(brate, 4);
    put_le({16'd0, align}, 2);
    put_le({16'd0, bits}, 2);
    if (!fmt_len[31] && fmt_len > 32'd16) repeat (fmt_len - 16) img.push_back(8'($urandom));
    for (int k = 0; k < n_other; k++) begin
      put_le(other_chunk_id(), 4);
      clen = $urandom_range(0, other_max);
      put_le(32'(clen), 4);
      repeat (clen) img.push_back(8'($urandom));
    end
    put_le(DATA_TEXT, 4);
    put_le(data_len, 4);
    repeat (n_smp) img.push_back(8'($urandom));
  endtask

  task automatic send_img(input int n_tail);
    in_byte_t x;
    for (int i = 0; i < img.size(); i++) begin
      x.b = img[i];
      x.nf = (i == 0);
      byte_q.push_back(x);
    end
    stim_count += img.size();
    repeat (n_tail) begin
      x.b = 8'($urandom);
      x.nf = 1'b0;
      byte_q.push_back(x);
    end
    do @(negedge clk); while (byte_q.size() > 16);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (byte_q.size() != 0 || s_axis_tvalid || parse_out_q.size() != 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_wav_pcm8_header_parser: done, errors");
    $finish;
  end

  initial begin
    int          r;
    int          n_other;
    int          n_smp;
    logic [31:0] fl;
    logic [31:0] rate;
    logic [31:0] brate;
    logic [31:0] dl;
    logic [15:0] tag;
    logic [15:0] chans;
    logic [15:0] align;
    logic [15:0] bits;

    @(negedge clk);
    while (rst) @(negedge clk);

    // directed files
    make_wav(16, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 8, 0, 0, 1, 1);
    send_img(0);
    make_wav(16, 1, 1, 0, 0, 1, 8, 0, 0, 3, 3);
    send_img(4);
    make_wav(20, 1, 1, 44100, 44100, 1, 8, 2, 0, 2, 2);
    send_img(0);
    make_wav(32'hFFFF_FFFF, 1, 1, 8000, 8000, 1, 8, 1, 3, 2, 2);
    send_img(0);
    make_wav(32'h8000_0000, 1, 1, 11025, 11025, 1, 8, 0, 0, 1, 1);
    send_img(0);
    make_wav(0, 1, 1, 22050, 22050, 1, 8, 1, 2, 0, 0);
    send_img(3);
    make_wav(16, 1, 1, 8000, 8000, 1, 8, 0, 0, 2, 2);
    img[0] ^= 8'h20;
    send_img(3);
    make_wav(16, 1, 1, 8000, 8000, 1, 8, 0, 0, 2, 2);
    img[15] ^= 8'h01;
    send_img(2);
    make_wav(16, 3, 1, 8000, 8000, 1, 8, 0, 0, 1, 1);
    send_img(1);
    make_wav(16, 1, 2, 8000, 8000, 1, 8, 0, 0, 1, 1);
    send_img(1);
    make_wav(16, 1, 1, 8000, 8000, 1, 16, 0, 0, 1, 1);
    send_img(1);
    make_wav(16, 1, 1, 8000, 16000, 1, 8, 0, 0, 1, 1);
    send_img(1);
    make_wav(16, 1, 1, 8000, 8000, 2, 8, 0, 0, 1, 1);
    send_img(1);
    // restart in the middle of a header, then of a long data chunk
    make_wav(16, 1, 1, 8000, 8000, 1, 8, 0, 0, 1, 1);
    img = img[0:9];
    send_img(0);
    make_wav(16, 1, 1, 48000, 48000, 1, 8, 0, 0, 32'hFFFF_FFFF, 6);
    send_img(0);
    drain();

    // random files
    while (stim_count < 1150) begin
      src_idle_en = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      if (stim_count > 1000) quiet = 1'b1;
      if (stim_count > 600 && stim_count < 700) drain();
      r = $urandom_range(0, 99);
      if (r < 6) begin
        img.delete();
        repeat ($urandom_range(1, 40)) img.push_back(8'($urandom));
        send_img(0);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: fl = 16;
          6, 7: fl = 16 + $urandom_range(1, 6);
          8: fl = $urandom_range(0, 15);
          default: fl = 32'h8000_0000 | $urandom;
        endcase
        case ($urandom_range(0, 9))
          0: rate = 32'd0;
          1: rate = 32'hFFFF_FFFF;
          default: rate = $urandom;
        endcase
        brate = rate;
        tag = 1;
        chans = 1;
        align = 1;
        bits = 8;
        n_other = $urandom_range(0, 2);
        if ($urandom_range(0, 19) == 0) begin
          dl = $urandom | 32'h8000_0000;
          n_smp = $urandom_range(1, 20);
        end else begin
          dl = $urandom_range(0, 30);
          n_smp = dl;
          if ($urandom_range(0, 9) == 0) n_smp = $urandom_range(0, dl);
        end
        if (r < 26) begin
          case ($urandom_range(0, 4))
            0: tag = 16'd1 ^ 16'($urandom_range(1, 65535));
            1: chans = 16'd1 ^ 16'($urandom_range(1, 65535));
            2: bits = 16'd8 ^ 16'($urandom_range(1, 65535));
            3: brate = rate ^ ($urandom | 32'd1);
            default: align = 16'd1 ^ 16'($urandom_range(1, 65535));
          endcase
        end
        make_wav(fl, tag, chans, rate, brate, align, bits, n_other, 6, dl, n_smp);
        if (r >= 26 && r < 34) begin
          case ($urandom_range(0, 2))
            0: img[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
            1: img[$urandom_range(8, 15)] ^= 8'($urandom_range(1, 255));
            default: img[$urandom_range(16, 35)] ^= 8'($urandom_range(1, 255));
          endcase
        end
        send_img($urandom_range(0, 3));
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && parse_out_q.size() == 0) begin
      $display("tb_wav_pcm8_header_parser: done, clean");
    end else begin
      $display("tb_wav_pcm8_header_parser: done, errors");
    end
    $finish;
  end

endmodule
